// ----- src/mcfl_pkg.sv -----
// Shared types and constants of the motor command frame link.
package mcfl_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned OUT_DATA_W  = 56;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    OP_SEND   = 2'd0,
    OP_RXBYTE = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_TX      = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_CSUMERR = 2'd2,
    KIND_TIMEOUT = 2'd3
  } kind_t;

  typedef enum logic {
    REG_ACK_CODE = 1'b0,
    REG_TIMEOUT  = 1'b1
  } reg_idx_t;

  localparam logic [7:0]  ACK_CODE_RST = 8'd100;
  localparam logic [15:0] TIMEOUT_RST  = 16'd50;
  localparam logic [15:0] TICK_SAT     = 16'hFFFF;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

endpackage

// ----- src/motor_command_frame_link_unit.sv -----
// Motor command frame link: command framing, reply parsing and reply timeout.
//
//  channel | ports                          | carries
//  --------+--------------------------------+------------------------------------
//  in      | in_tvalid/tready/tdata/tuser   | op (tuser), send fields, rx byte
//  out     | out_tvalid/tready/tdata/tuser  | kind (tuser), tx byte, reply, tlast
//  cfg     | cfg_valid/ready/index/data     | ack code, timeout ticks
//
// Received bytes, ticks and idle codes each give at most one result.
// A send puts out nine bytes; they leave the output register one per cycle unless it stalls,
// and no item is accepted until the last byte is loaded.
// Synchronous active-low reset: window closed, counters cleared, registers to defaults.
// A stalled output holds its item; input is taken only when the output register frees.
module motor_command_frame_link_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // module_address, command, cmd_type, motor, cmd_value, rx_byte
  input  logic [mcfl_pkg::IN_DATA_W-1:0]    in_tdata,
  // op
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // tx_byte, reply_status, reply_value, ack, zero fill
  output logic [mcfl_pkg::OUT_DATA_W-1:0]   out_tdata,
  // kind
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [mcfl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mcfl_pkg::*;

  logic [7:0]       ack_code_r;
  logic [15:0]      timeout_r;

  logic             window_r, window_nxt;
  logic [IDX_W-1:0] rx_idx_r, rx_idx_nxt;
  logic [15:0]      tick_r, tick_nxt;
  logic [7:0]       rx_sum_r, rx_sum_nxt;
  logic [7:0]       rx_status_r, rx_status_nxt;
  logic [31:0]      rx_value_r, rx_value_nxt;

  logic [63:0]      tx_shift_r, tx_shift_nxt;
  logic [IDX_W-1:0] tx_left_r, tx_left_nxt;

  logic             out_valid_r, out_valid_nxt;
  kind_t            out_kind_r, out_kind_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic [7:0]       out_status_r, out_status_nxt;
  logic [31:0]      out_value_r, out_value_nxt;
  logic             out_ack_r, out_ack_nxt;

  logic             out_free;
  logic             in_acc;
  op_t              op;
  logic [7:0]       f_addr, f_cmd, f_type, f_motor, f_rx;
  logic [31:0]      f_value;
  logic [7:0]       tx_sum;
  logic [15:0]      tick_inc;
  logic [15:0]      tick_limit;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = out_free && (tx_left_r == '0);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign op      = op_t'(in_tuser);
  assign f_addr  = in_tdata[7:0];
  assign f_cmd   = in_tdata[15:8];
  assign f_type  = in_tdata[23:16];
  assign f_motor = in_tdata[31:24];
  assign f_value = in_tdata[63:32];
  assign f_rx    = in_tdata[71:64];

  assign tx_sum = f_addr + f_cmd + f_type + f_motor
                + f_value[31:24] + f_value[23:16] + f_value[15:8] + f_value[7:0];
  assign tick_inc   = (tick_r == TICK_SAT) ? tick_r : tick_r + 16'd1;
  assign tick_limit = (timeout_r == '0) ? 16'd1 : timeout_r;

  always_comb begin
    window_nxt     = window_r;
    rx_idx_nxt     = rx_idx_r;
    tick_nxt       = tick_r;
    rx_sum_nxt     = rx_sum_r;
    rx_status_nxt  = rx_status_r;
    rx_value_nxt   = rx_value_r;
    tx_shift_nxt   = tx_shift_r;
    tx_left_nxt    = tx_left_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_ack_nxt    = out_ack_r;

    if (tx_left_r != '0 && out_free) begin
      out_valid_nxt  = 1'b1;
      out_kind_nxt   = KIND_TX;
      out_byte_nxt   = tx_shift_r[7:0];
      out_last_nxt   = (tx_left_r == IDX_W'(1));
      out_status_nxt = '0;
      out_value_nxt  = '0;
      out_ack_nxt    = 1'b0;
      tx_shift_nxt   = {8'd0, tx_shift_r[63:8]};
      tx_left_nxt    = tx_left_r - IDX_W'(1);
    end else if (in_acc) begin
      out_byte_nxt   = '0;
      out_last_nxt   = 1'b0;
      out_status_nxt = '0;
      out_value_nxt  = '0;
      out_ack_nxt    = 1'b0;
      case (op)
        OP_SEND: begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_TX;
          out_byte_nxt  = f_addr;
          tx_shift_nxt  = {tx_sum, f_value[7:0], f_value[15:8], f_value[23:16],
                           f_value[31:24], f_motor, f_type, f_cmd};
          tx_left_nxt   = LAST_IDX;
          window_nxt    = 1'b1;
          rx_idx_nxt    = '0;
          rx_sum_nxt    = '0;
          tick_nxt      = '0;
        end
        OP_RXBYTE: begin
          if (window_r) begin
            rx_idx_nxt = rx_idx_r + IDX_W'(1);
            rx_sum_nxt = rx_sum_r + f_rx;
            if (rx_idx_r == IDX_W'(2)) rx_status_nxt = f_rx;
            if (rx_idx_r >= IDX_W'(4) && rx_idx_r <= IDX_W'(7))
              rx_value_nxt = {rx_value_r[23:0], f_rx};
            if (rx_idx_r == LAST_IDX) begin
              window_nxt    = 1'b0;
              rx_idx_nxt    = '0;
              out_valid_nxt = 1'b1;
              if (rx_sum_r == f_rx) begin
                out_kind_nxt   = KIND_DONE;
                out_status_nxt = rx_status_r;
                out_value_nxt  = rx_value_r;
                out_ack_nxt    = (rx_status_r == ack_code_r);
              end else begin
                out_kind_nxt = KIND_CSUMERR;
              end
            end
          end
        end
        OP_TICK: begin
          if (window_r) begin
            tick_nxt = tick_inc;
            if (tick_inc >= tick_limit) begin
              window_nxt    = 1'b0;
              rx_idx_nxt    = '0;
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_code_r  <= ACK_CODE_RST;
      timeout_r   <= TIMEOUT_RST;
      window_r    <= 1'b0;
      rx_idx_r    <= '0;
      tick_r      <= '0;
      rx_sum_r    <= '0;
      tx_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_ACK_CODE: ack_code_r <= cfg_data[7:0];
          REG_TIMEOUT:  timeout_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      window_r    <= window_nxt;
      rx_idx_r    <= rx_idx_nxt;
      tick_r      <= tick_nxt;
      rx_sum_r    <= rx_sum_nxt;
      tx_left_r   <= tx_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rx_status_r  <= rx_status_nxt;
    rx_value_r   <= rx_value_nxt;
    tx_shift_r   <= tx_shift_nxt;
    out_kind_r   <= out_kind_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_ack_r    <= out_ack_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_ack_r, out_value_r, out_status_r, out_byte_r};

  a_no_accept_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_left_r != '0) |-> !in_tready)
    else $error("item accepted while a frame is still being sent");

  a_last_is_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_kind_r == KIND_TX))
    else $error("last marker on a non-transmit item");

  a_send_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == OP_SEND) |=> (window_r && out_valid_r && out_kind_r == KIND_TX
                                   && tx_left_r == LAST_IDX))
    else $error("send did not start a frame and open the window");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rx_idx_r <= LAST_IDX) && (tx_left_r <= LAST_IDX))
    else $error("frame counter out of range");

endmodule

// ----- tb/sv/motor_command_frame_link_unit_test.sv -----
// Self-checking testbench for the motor command frame link: table-driven and random traffic.
module motor_command_frame_link_unit_test;
  import mcfl_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int PART_B      = 14;
  localparam int NROWS       = 26;

  typedef struct {
    kind_t       kind;
    logic [7:0]  tx;
    logic        last;
    logic [7:0]  status;
    logic [31:0] value;
    logic        ack;
  } reply_t;

  typedef struct {
    op_t         op;
    logic [71:0] data;
    bit          typed;
    reply_t      res;
  } cmd_item_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = OP_NONE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic                  cfg_index  = REG_ACK_CODE;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  motor_command_frame_link_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor state
  logic [7:0]  rx_frame [FRAME_BYTES];
  int          rx_count    = 0;
  bit          win_open    = 0;
  logic [15:0] tick_cnt    = '0;
  logic [7:0]  cfg_ack     = ACK_CODE_RST;
  logic [15:0] cfg_timeout = TIMEOUT_RST;

  cmd_item_t   stim_q [$];
  reply_t      reply_q [$];
  cmd_item_t   cur_item;
  cmd_item_t   dir_tab [NROWS];
  int          n_pushed   = 0;
  int          n_accepted = 0;
  int          n_errors   = 0;
  int          n_cycles   = 0;
  int          gap_left   = 0;
  int          burst_left = 0;
  int          rx_mode    = 0;
  bit          hold_off   = 0;

  function automatic reply_t mk_reply(kind_t k, logic [7:0] tx, logic lst, logic [7:0] st,
                                      logic [31:0] val, logic ak);
    reply_t r;
    r.kind   = k;
    r.tx     = tx;
    r.last   = lst;
    r.status = st;
    r.value  = val;
    r.ack    = ak;
    return r;
  endfunction

  // tdata: module_address, command, cmd_type, motor, cmd_value, rx_byte
  function automatic cmd_item_t row(op_t op, logic [7:0] a, logic [7:0] c, logic [7:0] t,
                                    logic [7:0] m, logic [31:0] v, logic [7:0] rx);
    cmd_item_t it;
    it.op    = op;
    it.data  = {rx, v, m, t, c, a};
    it.typed = 0;
    it.res   = mk_reply(KIND_TX, '0, 1'b0, '0, '0, 1'b0);
    return it;
  endfunction

  function automatic cmd_item_t chk(cmd_item_t it, kind_t k, logic [7:0] st, logic [31:0] val,
                                    logic ak);
    it.typed = 1;
    it.res   = mk_reply(k, '0, 1'b0, st, val, ak);
    return it;
  endfunction

  function automatic void push_item(op_t op, logic [71:0] d);
    cmd_item_t it;
    it.op    = op;
    it.data  = d;
    it.typed = 0;
    it.res   = mk_reply(KIND_TX, '0, 1'b0, '0, '0, 1'b0);
    stim_q.push_back(it);
    n_pushed++;
  endfunction

  function automatic logic [71:0] rnd_data();
    return {8'($urandom), $urandom, $urandom};
  endfunction

  function automatic logic [71:0] rx_data(logic [7:0] b);
    return {b, $urandom, $urandom};
  endfunction

  function automatic logic [7:0] byte_sum8(logic [7:0] b [FRAME_BYTES]);
    logic [7:0] s;
    s = '0;
    for (int i = 0; i < 8; i++) s = s + b[i];
    return s;
  endfunction

  function automatic void link_predict(cmd_item_t it);
    logic [7:0]  tx [FRAME_BYTES];
    logic [15:0] lim;
    int          n0;
    n0 = reply_q.size();
    case (it.op)
      OP_SEND: begin
        for (int i = 0; i < 4; i++) tx[i] = it.data[8*i +: 8];
        for (int i = 0; i < 4; i++) tx[4+i] = it.data[56-8*i +: 8];
        tx[8] = byte_sum8(tx);
        for (int i = 0; i < FRAME_BYTES; i++)
          reply_q.push_back(mk_reply(KIND_TX, tx[i], i == FRAME_BYTES - 1, '0, '0, 1'b0));
        rx_count = 0;
        win_open = 1;
        tick_cnt = '0;
      end
      OP_RXBYTE: begin
        if (win_open && rx_count < FRAME_BYTES) begin
          rx_frame[rx_count] = it.data[71:64];
          rx_count++;
          if (rx_count == FRAME_BYTES) begin
            win_open = 0;
            rx_count = 0;
            if (byte_sum8(rx_frame) == rx_frame[8])
              reply_q.push_back(mk_reply(KIND_DONE, '0, 1'b0, rx_frame[2],
                                         {rx_frame[4], rx_frame[5], rx_frame[6], rx_frame[7]},
                                         rx_frame[2] == cfg_ack));
            else
              reply_q.push_back(mk_reply(KIND_CSUMERR, '0, 1'b0, '0, '0, 1'b0));
          end
        end
      end
      OP_TICK: begin
        lim = (cfg_timeout == 0) ? 16'd1 : cfg_timeout;
        if (win_open) begin
          if (tick_cnt != TICK_SAT) tick_cnt++;
          if (tick_cnt >= lim) begin
            win_open = 0;
            rx_count = 0;
            reply_q.push_back(mk_reply(KIND_TIMEOUT, '0, 1'b0, '0, '0, 1'b0));
          end
        end
      end
      default: ;
    endcase
    // hand-typed expectation replaces the computed one
    if (it.typed) begin
      while (reply_q.size() > n0) void'(reply_q.pop_back());
      reply_q.push_back(it.res);
    end
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        link_predict(cur_item);
        n_accepted++;
      end
      if (in_tvalid && !in_tready) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        cur_item = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= cur_item.data;
        in_tuser  <= cur_item.op;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern redrawn at random from four modes
  always @(posedge clk) begin
    if (n_cycles % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       out_tready <= !hold_off;
      1:       out_tready <= !hold_off && $urandom_range(0, 1);
      2:       out_tready <= !hold_off && (n_cycles % 7 >= 3);
      default: out_tready <= !hold_off && ($urandom_range(0, 7) != 0);
    endcase
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (n_accepted >= 50);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  function automatic void note_error(string msg);
    n_errors++;
    if (n_errors <= 10) $display("%s", msg);
  endfunction

  // out_tdata: tx_byte, reply_status, reply_value, ack
  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = mk_reply(kind_t'(out_tuser), out_tdata[7:0], out_tlast, out_tdata[15:8],
                     out_tdata[47:16], out_tdata[48]);
      if (reply_q.size() == 0) begin
        note_error($sformatf("unexpected item: kind %s tx %h last %b st %h val %h ack %b",
                             got.kind.name(), got.tx, got.last, got.status, got.value,
                             got.ack));
      end else begin
        want = reply_q.pop_front();
        if (want.kind != got.kind || want.tx != got.tx || want.last != got.last ||
            want.status != got.status || want.value != got.value || want.ack != got.ack)
          note_error($sformatf({"mismatch: exp kind %s tx %h last %b st %h val %h ack %b,",
                                " got kind %s tx %h last %b st %h val %h ack %b"},
                               want.kind.name(), want.tx, want.last, want.status, want.value,
                               want.ack, got.kind.name(), got.tx, got.last, got.status,
                               got.value, got.ack));
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (n_accepted != n_pushed || reply_q.size() != 0) @(negedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_ACK_CODE) cfg_ack = val[7:0];
    else cfg_timeout = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_traffic(int n_items);
    int          start;
    int          r;
    int          c;
    int          nb;
    int          nt;
    int          pos;
    int          lim;
    logic [7:0]  b [FRAME_BYTES];
    start = n_pushed;
    while (n_pushed - start < n_items) begin
      lim = (cfg_timeout == 0) ? 1 : cfg_timeout;
      r   = $urandom_range(0, 99);
      if (r < 70) begin
        push_item(OP_SEND, rnd_data());
        c = $urandom_range(0, 99);
        if (c < 75) begin
          for (int i = 0; i < 8; i++) b[i] = 8'($urandom);
          if ($urandom_range(0, 1)) b[2] = cfg_ack;
          b[8] = byte_sum8(b);
          if (c >= 50) b[8] = b[8] ^ (8'd1 << $urandom_range(0, 7));
          // one stray tick inside the frame, below the limit
          pos = (lim > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : FRAME_BYTES;
          for (int i = 0; i < FRAME_BYTES; i++) begin
            if (i == pos) push_item(OP_TICK, rnd_data());
            push_item(OP_RXBYTE, rx_data(b[i]));
          end
        end else begin
          nb = $urandom_range(0, 8);
          nt = (lim <= 16) ? lim : $urandom_range(1, 5);
          for (int i = 0; i < nb; i++) push_item(OP_RXBYTE, rx_data(8'($urandom)));
          for (int i = 0; i < nt; i++) push_item(OP_TICK, rnd_data());
        end
      end else if (r < 80) begin
        // open window left for the next send to restart
        push_item(OP_SEND, rnd_data());
        nb = $urandom_range(0, 8);
        for (int i = 0; i < nb; i++) push_item(OP_RXBYTE, rx_data(8'($urandom)));
      end else begin
        case ($urandom_range(0, 2))
          0:       push_item(OP_TICK, rnd_data());
          1:       push_item(OP_RXBYTE, rnd_data());
          default: push_item(OP_NONE, rnd_data());
        endcase
      end
    end
  endtask

  initial begin
    for (int i = 0; i < FRAME_BYTES; i++) rx_frame[i] = '0;

    //                  op          addr   cmd    type   motor  value          rx
    dir_tab[0]  = row(OP_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h00);
    dir_tab[1]  = row(OP_RXBYTE,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'hFF);
    dir_tab[2]  = row(OP_NONE,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    dir_tab[3]  = row(OP_SEND,    8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h00);
    dir_tab[4]  = row(OP_SEND,    8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    dir_tab[5]  = row(OP_RXBYTE,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h01);
    dir_tab[6]  = row(OP_RXBYTE,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h02);
    dir_tab[7]  = row(OP_RXBYTE,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h64);
    dir_tab[8]  = row(OP_RXBYTE,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h03);
    dir_tab[9]  = row(OP_RXBYTE,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h80);
    dir_tab[10] = row(OP_RXBYTE,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h00);
    dir_tab[11] = row(OP_RXBYTE,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h00);
    dir_tab[12] = row(OP_RXBYTE,  8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h00);
    dir_tab[13] = chk(row(OP_RXBYTE, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'hEA),
                      KIND_DONE, 8'd100, 32'h8000_0000, 1'b1);
    // zero timeout and zero ack code from here
    dir_tab[14] = row(OP_SEND,    8'h01, 8'h02, 8'h03, 8'h04, 32'h7FFF_FFFF, 8'h00);
    dir_tab[15] = chk(row(OP_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h00),
                      KIND_TIMEOUT, 8'h00, 32'h0, 1'b0);
    dir_tab[16] = row(OP_SEND,    8'h80, 8'h7F, 8'h55, 8'hAA, 32'h1234_5678, 8'h00);
    for (int i = 17; i < 25; i++)
      dir_tab[i] = row(OP_RXBYTE, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h01);
    dir_tab[25] = chk(row(OP_RXBYTE, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0000_0000, 8'h00),
                      KIND_CSUMERR, 8'h00, 32'h0, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NROWS; i++) begin
      if (i == PART_B) begin
        wait_idle();
        write_reg(REG_TIMEOUT, 16'd0);
        write_reg(REG_ACK_CODE, 16'd0);
      end
      stim_q.push_back(dir_tab[i]);
      n_pushed++;
    end

    wait_idle();
    write_reg(REG_ACK_CODE, 16'($urandom_range(0, 255)));
    write_reg(REG_TIMEOUT, 16'd1);
    run_traffic(70);

    wait_idle();
    write_reg(REG_ACK_CODE, 16'd255);
    write_reg(REG_TIMEOUT, 16'($urandom_range(2, 12)));
    run_traffic(70);

    // longest timeout
    wait_idle();
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_ACK_CODE, 16'($urandom_range(0, 255)));
    run_traffic(30);

    wait_idle();
    write_reg(REG_ACK_CODE, 16'($urandom_range(0, 255)));
    write_reg(REG_TIMEOUT, 16'($urandom_range(3, 16)));
    run_traffic(70);

    wait_idle();
    repeat (20) @(posedge clk);
    if (n_errors == 0 && reply_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/mcfl_pkg.sv
src/motor_command_frame_link_unit.sv
tb/sv/motor_command_frame_link_unit_test.sv
